[sv/ppt_pkg.sv]
// ============================================================================
// ppt_pkg
// Shared types and constants for the parent-pointer tree table.
// ============================================================================
package ppt_pkg;

    localparam int KEY_BITS      = 16;
    localparam int INDEX_BITS    = 6;
    localparam int STATUS_BITS   = 3;
    localparam int OP_BITS       = 2;
    localparam int DEF_NODES     = 64;
    localparam int DEF_KEY_WIDTH = 16;

    typedef enum logic [OP_BITS-1:0] {
        OP_INSERT   = 2'd0,
        OP_FIND     = 2'd1,
        OP_CHILDREN = 2'd2,
        OP_PARENT   = 2'd3
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK      = 3'd0,
        ST_MISSING = 3'd1,
        ST_FULL    = 3'd2,
        ST_LEAF    = 3'd3,
        ST_ROOT    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_WRITE,
        S_KIDS,
        S_KEND,
        S_PKEY
    } ctrl_state_t;

    // Control of the entry ring: shift rotates every cell by one place,
    // load replaces the word entering the tail cell.
    typedef struct packed {
        logic shift;
        logic load;
    } ring_ctl_t;

endpackage

[sv/ppt_cell.sv]
// ============================================================================
// ppt_cell
// One entry of the rotating table: a key and a parent index, passed on to
// the neighbor cell whenever the ring shifts.
// ============================================================================
module ppt_cell #(
    parameter int KW       = ppt_pkg::DEF_KEY_WIDTH,
    parameter int IW       = ppt_pkg::INDEX_BITS,
    parameter bit LOADABLE = 1'b0
) (
    input  logic              aclk,
    input  ppt_pkg::ring_ctl_t ctl,
    input  logic [KW-1:0]     nb_key,
    input  logic [IW-1:0]     nb_parent,
    input  logic [KW-1:0]     wr_key,
    input  logic [IW-1:0]     wr_parent,
    output logic [KW-1:0]     q_key,
    output logic [IW-1:0]     q_parent
);
    import ppt_pkg::*;

    logic [KW-1:0] key_reg;
    logic [IW-1:0] parent_reg;

    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            if (LOADABLE && ctl.load) begin
                key_reg    <= wr_key;
                parent_reg <= wr_parent;
            end else begin
                key_reg    <= nb_key;
                parent_reg <= nb_parent;
            end
        end
    end

    assign q_key    = key_reg;
    assign q_parent = parent_reg;

endmodule

[sv/ppt_ctrl.sv]
// ============================================================================
// ppt_ctrl
// Sequencer at the head of the entry ring: tracks which index sits in the
// head cell, runs the lookup and child sweeps, and holds the output word.
// ============================================================================
module ppt_ctrl #(
    parameter int NODES     = ppt_pkg::DEF_NODES,
    parameter int KEY_WIDTH = ppt_pkg::DEF_KEY_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ppt_pkg::OP_BITS-1:0]       s_op,
    input  logic [ppt_pkg::KEY_BITS-1:0]      s_key,
    input  logic [ppt_pkg::KEY_BITS-1:0]      s_parent_key,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ppt_pkg::STATUS_BITS-1:0]   m_status,
    output logic [ppt_pkg::INDEX_BITS-1:0]    m_node_index,
    output logic [ppt_pkg::KEY_BITS-1:0]      m_result_key,
    output logic                              m_last,
    input  logic [ppt_pkg::KEY_BITS-1:0]      root_key,
    input  logic [((KEY_WIDTH < ppt_pkg::KEY_BITS) ? KEY_WIDTH : ppt_pkg::KEY_BITS)-1:0]
                                              head_key,
    input  logic [$clog2(NODES)-1:0]          head_parent,
    output ppt_pkg::ring_ctl_t                ring_ctl,
    output logic [((KEY_WIDTH < ppt_pkg::KEY_BITS) ? KEY_WIDTH : ppt_pkg::KEY_BITS)-1:0]
                                              wr_key,
    output logic [$clog2(NODES)-1:0]          wr_parent
);
    import ppt_pkg::*;

    localparam int SW = (KEY_WIDTH < KEY_BITS) ? KEY_WIDTH : KEY_BITS;
    localparam int IW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);

    ctrl_state_t   state_reg, state_next;
    op_t           op_reg, op_next;
    logic [SW-1:0] key_reg, key_next;
    logic [SW-1:0] pkey_reg, pkey_next;
    logic [IW-1:0] m_reg, m_next;
    logic          started_reg, started_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [IW-1:0] pend_idx_reg, pend_idx_next;
    logic [SW-1:0] pend_key_reg, pend_key_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] head_idx_reg;

    logic          m_valid_reg;
    status_t       m_status_reg;
    logic [IW-1:0] m_index_reg;
    logic [SW-1:0] m_rkey_reg;
    logic          m_last_reg;

    logic          emit_req;
    status_t       emit_status;
    logic [IW-1:0] emit_idx;
    logic [SW-1:0] emit_key;
    logic          emit_last;
    logic          wr_load;

    logic          out_free;
    logic          advance;
    logic          act;
    logic          at_end;
    logic          full;
    logic          hit;
    logic          child;
    logic [SW-1:0] head_key_eff;
    logic [SW-1:0] target;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = !(emit_req && !out_free);

    // Entry 0 always reads the root register instead of its cell.
    assign head_key_eff = (head_idx_reg == '0) ? root_key[SW-1:0] : head_key;
    assign target       = (op_reg == OP_INSERT) ? pkey_reg : key_reg;
    assign act          = started_reg || (head_idx_reg == '0);
    assign at_end       = CW'(head_idx_reg) == (count_reg - CW'(1));
    assign full         = count_reg == CW'(NODES);
    assign hit          = head_key_eff == target;
    assign child        = (head_idx_reg != '0) && (head_parent == m_reg);

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        pkey_next       = pkey_reg;
        m_next          = m_reg;
        started_next    = started_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_key_next   = pend_key_reg;
        count_next      = count_reg;
        s_ready         = 1'b0;
        emit_req        = 1'b0;
        emit_status     = ST_OK;
        emit_idx        = '0;
        emit_key        = '0;
        emit_last       = 1'b1;
        wr_load         = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next         = op_t'(s_op);
                    key_next        = s_key[SW-1:0];
                    pkey_next       = s_parent_key[SW-1:0];
                    started_next    = 1'b0;
                    pend_valid_next = 1'b0;
                    state_next      = S_LOOK;
                end
            end

            S_LOOK: begin
                if (op_reg == OP_INSERT && full) begin
                    emit_req    = 1'b1;
                    emit_status = ST_FULL;
                    state_next  = S_IDLE;
                end else if (act) begin
                    started_next = 1'b1;
                    if (hit) begin
                        m_next       = head_idx_reg;
                        started_next = 1'b0;
                        unique case (op_reg)
                            OP_INSERT: begin
                                state_next = S_WRITE;
                            end
                            OP_FIND: begin
                                emit_req   = 1'b1;
                                emit_idx   = head_idx_reg;
                                state_next = S_IDLE;
                            end
                            OP_CHILDREN: begin
                                state_next = S_KIDS;
                            end
                            OP_PARENT: begin
                                if (head_idx_reg == '0) begin
                                    emit_req    = 1'b1;
                                    emit_status = ST_ROOT;
                                    state_next  = S_IDLE;
                                end else if (head_parent == '0) begin
                                    emit_req   = 1'b1;
                                    emit_key   = root_key[SW-1:0];
                                    state_next = S_IDLE;
                                end else begin
                                    m_next     = head_parent;
                                    state_next = S_PKEY;
                                end
                            end
                        endcase
                    end else if (at_end) begin
                        emit_req    = 1'b1;
                        emit_status = ST_MISSING;
                        state_next  = S_IDLE;
                    end
                end
            end

            S_WRITE: begin
                // The new entry enters the tail as its index leaves the head.
                if (CW'(head_idx_reg) == count_reg) begin
                    wr_load    = 1'b1;
                    emit_req   = 1'b1;
                    emit_idx   = head_idx_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_IDLE;
                end
            end

            S_KIDS: begin
                // Each child is held back one step so the final one can be
                // marked as last when the sweep ends.
                if (act) begin
                    started_next = 1'b1;
                    if (child) begin
                        if (pend_valid_reg) begin
                            emit_req  = 1'b1;
                            emit_idx  = pend_idx_reg;
                            emit_key  = pend_key_reg;
                            emit_last = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = head_idx_reg;
                        pend_key_next   = head_key;
                    end
                    if (at_end) begin
                        state_next = S_KEND;
                    end
                end
            end

            S_KEND: begin
                emit_req   = 1'b1;
                state_next = S_IDLE;
                if (pend_valid_reg) begin
                    emit_idx = pend_idx_reg;
                    emit_key = pend_key_reg;
                end else begin
                    emit_status = ST_LEAF;
                end
            end

            S_PKEY: begin
                if (head_idx_reg == m_reg) begin
                    emit_req   = 1'b1;
                    emit_idx   = head_idx_reg;
                    emit_key   = head_key;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            started_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            count_reg      <= CW'(1);
            head_idx_reg   <= '0;
        end else if (advance) begin
            state_reg      <= state_next;
            started_reg    <= started_next;
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
            head_idx_reg   <= (head_idx_reg == IW'(NODES - 1)) ? '0 : head_idx_reg + IW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            op_reg       <= op_next;
            key_reg      <= key_next;
            pkey_reg     <= pkey_next;
            m_reg        <= m_next;
            pend_idx_reg <= pend_idx_next;
            pend_key_reg <= pend_key_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_req && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_req && out_free) begin
            m_status_reg <= emit_status;
            m_index_reg  <= emit_idx;
            m_rkey_reg   <= emit_key;
            m_last_reg   <= emit_last;
        end
    end

    assign ring_ctl.shift = advance;
    assign ring_ctl.load  = wr_load;
    assign wr_key         = key_reg;
    assign wr_parent      = m_reg;

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_node_index = INDEX_BITS'(m_index_reg);
    assign m_result_key = KEY_BITS'(m_rkey_reg);
    assign m_last       = m_last_reg;

endmodule

[sv/parent_pointer_tree_table_unit.sv]
// ============================================================================
// parent_pointer_tree_table_unit
// Tree table in parent-array form, kept in a rotating ring of entry cells.
// ============================================================================
//
//  Channel   Ports                                  Role
//  --------  -------------------------------------  ----------------------------
//  input     s_valid/s_ready, s_op, s_key,          one operation word
//            s_parent_key
//  result    m_valid/m_ready, m_status,             one or more words per input
//            m_node_index, m_result_key, m_last
//  config    cfg_wr_en, cfg_wr_data                 root key, no wait
//
// The ring rotates one cell per cycle and the sequencer sees one entry per
// cycle at its head, so every sweep starts when entry 0 comes around. An
// operation waits for entry 0 to reach the head, makes one pass for the key
// lookup, and one more pass for an insert, a parent key or the child list.
// One word is taken at a time. Reset leaves only the root entry; no clearing
// pass is needed. A stalled result stops the ring.
//
module parent_pointer_tree_table_unit #(
    parameter int NODES     = ppt_pkg::DEF_NODES,
    parameter int KEY_WIDTH = ppt_pkg::DEF_KEY_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ppt_pkg::OP_BITS-1:0]     s_op,
    input  logic [ppt_pkg::KEY_BITS-1:0]    s_key,
    input  logic [ppt_pkg::KEY_BITS-1:0]    s_parent_key,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ppt_pkg::STATUS_BITS-1:0] m_status,
    output logic [ppt_pkg::INDEX_BITS-1:0]  m_node_index,
    output logic [ppt_pkg::KEY_BITS-1:0]    m_result_key,
    output logic                            m_last,
    input  logic                            cfg_wr_en,
    input  logic [ppt_pkg::KEY_BITS-1:0]    cfg_wr_data
);
    import ppt_pkg::*;

    localparam int SW = (KEY_WIDTH < KEY_BITS) ? KEY_WIDTH : KEY_BITS;
    localparam int IW = $clog2(NODES);

    logic [KEY_BITS-1:0] root_key_reg;
    logic [SW-1:0]       cell_key    [NODES];
    logic [IW-1:0]       cell_parent [NODES];
    ring_ctl_t           ring_ctl;
    logic [SW-1:0]       wr_key;
    logic [IW-1:0]       wr_parent;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_key_reg <= '0;
        end else if (cfg_wr_en) begin
            root_key_reg <= cfg_wr_data;
        end
    end

    // Cell 0 is the head; the tail cell wraps around from it.
    for (genvar c = 0; c < NODES; c++) begin : g_cell
        localparam int NB = (c == NODES - 1) ? 0 : c + 1;

        ppt_cell #(
            .KW       (SW),
            .IW       (IW),
            .LOADABLE (c == NODES - 1)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ring_ctl),
            .nb_key    (cell_key[NB]),
            .nb_parent (cell_parent[NB]),
            .wr_key    (wr_key),
            .wr_parent (wr_parent),
            .q_key     (cell_key[c]),
            .q_parent  (cell_parent[c])
        );
    end

    ppt_ctrl #(
        .NODES     (NODES),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_key        (s_key),
        .s_parent_key (s_parent_key),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_node_index (m_node_index),
        .m_result_key (m_result_key),
        .m_last       (m_last),
        .root_key     (root_key_reg),
        .head_key     (cell_key[0]),
        .head_parent  (cell_parent[0]),
        .ring_ctl     (ring_ctl),
        .wr_key       (wr_key),
        .wr_parent    (wr_parent)
    );

    // A table write always comes with a successful insert result.
    a_write_reports_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (ring_ctl.load && ring_ctl.shift) |=> (m_valid && m_status == ST_OK))
        else $error("table write without an ok result");

    // Only one operation is in progress at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an operation is in progress");

    // The table is never written while waiting for a new word.
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !ring_ctl.load)
        else $error("table write while idle");

    // A held result stops the ring.
    a_stall_holds_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && !s_ready && !ring_ctl.shift) |=> !s_ready)
        else $error("operation finished while its result was blocked");

endmodule

[tb/tb_parent_pointer_tree_table_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_parent_pointer_tree_table_unit
// Drives insert, find, children and parent operations into the tree table,
// keeps its own copy of the parent-array tree to predict every result word,
// and compares each result word field by field. The root key is rewritten
// between phases, and both channels idle.
// ============================================================================
module tb_parent_pointer_tree_table_unit;

    import ppt_pkg::*;

    localparam int TREE_NODES  = 64;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        op_t                 op;
        logic [KEY_BITS-1:0] key;
        logic [KEY_BITS-1:0] pkey;
    } tree_req_t;

    typedef struct packed {
        status_t               status;
        logic [INDEX_BITS-1:0] idx;
        logic [KEY_BITS-1:0]   rkey;
        logic                  last;
    } tree_word_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    op_t                    s_op = OP_FIND;
    logic [KEY_BITS-1:0]    s_key = '0;
    logic [KEY_BITS-1:0]    s_parent_key = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [STATUS_BITS-1:0] m_status;
    logic [INDEX_BITS-1:0]  m_node_index;
    logic [KEY_BITS-1:0]    m_result_key;
    logic                   m_last;
    logic                   cfg_wr_en = 1'b0;
    logic [KEY_BITS-1:0]    cfg_wr_data = '0;

    // Shadow copy of the tree.
    logic [KEY_BITS-1:0]    tree_key [TREE_NODES];
    logic [INDEX_BITS-1:0]  tree_parent [TREE_NODES];
    int                     tree_count = 1;
    logic [KEY_BITS-1:0]    tree_root_key = '0;

    tree_req_t              pend_items[$];
    tree_word_t             expected_words[$];
    int                     issued_cnt = 0;
    int                     accepted_cnt = 0;
    int                     mismatches = 0;
    int                     words_seen = 0;
    longint                 cycles = 0;

    logic [KEY_BITS-1:0]    key_pool [12];

    int                     burst_left = 1;
    int                     gap_left = 0;
    tree_req_t              next_req;

    int                     rx_tick = 0;
    int                     hold_left = 0;
    bit                     hold_done = 1'b0;
    tree_word_t             exp_word;

    parent_pointer_tree_table_unit i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_key        (s_key),
        .s_parent_key (s_parent_key),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_node_index (m_node_index),
        .m_result_key (m_result_key),
        .m_last       (m_last),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic log_mismatch(string msg);
        // Output is capped so a badly broken block cannot flood the log.
        if (mismatches < 100) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    function automatic int lowest_match(logic [KEY_BITS-1:0] k);
        for (int i = 0; i < tree_count; i++) begin
            if (((i == 0) ? tree_root_key : tree_key[i]) == k) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void expect_word(status_t st, int idx, logic [KEY_BITS-1:0] rk);
        expected_words.push_back('{st, idx[INDEX_BITS-1:0], rk, 1'b1});
    endfunction

    // Applies one operation to the shadow tree and queues its result words.
    function automatic void tree_apply(op_t op, logic [KEY_BITS-1:0] key,
                                       logic [KEY_BITS-1:0] pkey);
        int         hit;
        int         kids;
        int         up;
        tree_word_t held;
        if (op == OP_INSERT) begin
            if (tree_count >= TREE_NODES) begin
                expect_word(ST_FULL, 0, '0);
                return;
            end
            hit = lowest_match(pkey);
            if (hit < 0) begin
                expect_word(ST_MISSING, 0, '0);
                return;
            end
            tree_key[tree_count] = key;
            tree_parent[tree_count] = hit[INDEX_BITS-1:0];
            expect_word(ST_OK, tree_count, '0);
            tree_count++;
            return;
        end
        hit = lowest_match(key);
        if (hit < 0) begin
            expect_word(ST_MISSING, 0, '0);
            return;
        end
        case (op)
            OP_FIND: begin
                expect_word(ST_OK, hit, '0);
            end
            OP_CHILDREN: begin
                kids = 0;
                held = '0;
                for (int i = 1; i < tree_count; i++) begin
                    if (tree_parent[i] == hit[INDEX_BITS-1:0]) begin
                        if (kids > 0) begin
                            expected_words.push_back(held);
                        end
                        held = '{ST_OK, i[INDEX_BITS-1:0], tree_key[i], 1'b0};
                        kids++;
                    end
                end
                if (kids == 0) begin
                    expect_word(ST_LEAF, 0, '0);
                end else begin
                    held.last = 1'b1;
                    expected_words.push_back(held);
                end
            end
            default: begin
                if (hit == 0) begin
                    expect_word(ST_ROOT, 0, '0);
                end else begin
                    up = int'(tree_parent[hit]);
                    expect_word(ST_OK, up, (up == 0) ? tree_root_key : tree_key[up]);
                end
            end
        endcase
    endfunction

    // Sender: bursts of words separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                tree_apply(s_op, s_key, s_parent_key);
                accepted_cnt++;
            end
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pend_items.size() > 0) begin
                    next_req = pend_items.pop_front();
                    s_valid <= 1'b1;
                    s_op <= next_req.op;
                    s_key <= next_req.key;
                    s_parent_key <= next_req.pkey;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 12);
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: gap_left = 0;
                            4, 5, 6, 7: gap_left = $urandom_range(1, 4);
                            default:    gap_left = $urandom_range(10, 40);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result word and stalls on its own schedule.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                words_seen++;
                if (expected_words.size() == 0) begin
                    log_mismatch("result word arrived with nothing expected");
                end else begin
                    exp_word = expected_words.pop_front();
                    if (m_status !== exp_word.status)
                        log_mismatch($sformatf("status %0d, expected %0d",
                                               m_status, exp_word.status));
                    if (m_node_index !== exp_word.idx)
                        log_mismatch($sformatf("node_index %0d, expected %0d",
                                               m_node_index, exp_word.idx));
                    if (m_result_key !== exp_word.rkey)
                        log_mismatch($sformatf("result_key %h, expected %h",
                                               m_result_key, exp_word.rkey));
                    if (m_last !== exp_word.last)
                        log_mismatch($sformatf("last %b, expected %b",
                                               m_last, exp_word.last));
                end
            end
            rx_tick++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && words_seen >= 60) begin
                // One long hold-off so the block backs up into its input.
                hold_done = 1'b1;
                hold_left = 800;
                m_ready <= 1'b0;
            end else begin
                case ((rx_tick / 150) % 4)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= (rx_tick % 5 != 0);
                endcase
            end
        end
    end

    task automatic queue_item(op_t op, logic [KEY_BITS-1:0] key, logic [KEY_BITS-1:0] pkey);
        pend_items.push_back('{op, key, pkey});
        issued_cnt++;
    endtask

    task automatic wait_drained();
        wait (accepted_cnt == issued_cnt && expected_words.size() == 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_root(logic [KEY_BITS-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        tree_root_key = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key();
        if ($urandom_range(0, 99) < 85) begin
            return key_pool[$urandom_range(0, 11)];
        end
        return KEY_BITS'($urandom);
    endfunction

    task automatic random_phase(int n);
        op_t                 op;
        logic [KEY_BITS-1:0] k;
        logic [KEY_BITS-1:0] p;
        for (int j = 0; j < n; j++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6: op = OP_INSERT;
                7, 8, 9, 10:         op = OP_FIND;
                11, 12, 13, 14, 15:  op = OP_CHILDREN;
                default:             op = OP_PARENT;
            endcase
            k = pick_key();
            p = (op == OP_INSERT) ? pick_key() : KEY_BITS'($urandom);
            queue_item(op, k, p);
        end
    endtask

    initial begin
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        key_pool[2] = 16'hAAAA;
        key_pool[3] = 16'h5555;
        for (int i = 4; i < 12; i++) begin
            key_pool[i] = KEY_BITS'($urandom);
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Root key is zero out of reset.
        queue_item(OP_PARENT,   16'h0000, 16'hFFFF);
        queue_item(OP_CHILDREN, 16'h0000, 16'h0000);
        queue_item(OP_FIND,     16'h0000, 16'h0000);
        queue_item(OP_FIND,     16'hFFFF, 16'h0000);
        queue_item(OP_CHILDREN, 16'h1234, 16'h0000);
        queue_item(OP_PARENT,   16'h1234, 16'h0000);
        queue_item(OP_INSERT,   16'hFFFF, 16'h5555);
        queue_item(OP_INSERT,   16'hFFFF, 16'h0000);
        queue_item(OP_INSERT,   16'h0000, 16'hFFFF);
        queue_item(OP_INSERT,   16'hAAAA, 16'h0000);
        queue_item(OP_INSERT,   16'h5555, 16'hFFFF);
        queue_item(OP_INSERT,   16'hFFFF, 16'hAAAA);
        queue_item(OP_FIND,     16'hFFFF, 16'h0000);
        queue_item(OP_FIND,     16'hAAAA, 16'h0000);
        queue_item(OP_CHILDREN, 16'h0000, 16'h0000);
        queue_item(OP_CHILDREN, 16'hFFFF, 16'h0000);
        queue_item(OP_CHILDREN, 16'h5555, 16'h0000);
        queue_item(OP_PARENT,   16'h5555, 16'h0000);
        queue_item(OP_PARENT,   16'hFFFF, 16'h0000);
        wait_drained();

        // With the root renamed, the duplicate key 0 becomes a plain entry.
        write_root(16'hFFFF);
        queue_item(OP_FIND,     16'hFFFF, 16'h0000);
        queue_item(OP_CHILDREN, 16'hFFFF, 16'h0000);
        queue_item(OP_PARENT,   16'h0000, 16'h0000);
        queue_item(OP_PARENT,   16'hFFFF, 16'h0000);
        random_phase(70);
        wait_drained();

        write_root(16'h0000);
        random_phase(60);
        wait_drained();

        write_root(key_pool[$urandom_range(2, 11)]);
        random_phase(70);
        wait_drained();

        repeat (200) @(posedge aclk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[sim.f]
sv/ppt_pkg.sv
sv/ppt_cell.sv
sv/ppt_ctrl.sv
sv/parent_pointer_tree_table_unit.sv
tb/tb_parent_pointer_tree_table_unit.sv
